/* rtl/core/nhb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhb_pkg
// shared types and constants of the histogram binner
// ----------------------------------------------------------------------------
package nhb_pkg;

    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 32;
    localparam int VALUE_W  = 31;
    localparam int CNT_W    = 31;
    localparam int SUM_W    = 63;
    localparam int SQ_W     = 62;
    localparam int TOTAL_W  = 32;
    localparam int BUCKET_W = 6;
    localparam int ACTIVE_W = 7;

    localparam logic [VALUE_W-1:0] TOP_SAMPLE = 31'h7FFF_FFFE;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = 31'h7FFF_FFFF;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 31'h7FFF_FFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 32'hFFFF_FFFF;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD         = 2'd0,
        CMD_WRITE_BOUND = 2'd1,
        CMD_READ        = 2'd2,
        CMD_CLEAR       = 2'd3
    } t_cmd;

    typedef struct packed {
        logic add;
        logic clear;
    } t_stats_ctl;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   sq_sum;
        logic [TOTAL_W-1:0] total;
    } t_stats;

endpackage : nhb_pkg
`default_nettype wire

/* rtl/core/nonuniform_histogram_binner_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonuniform_histogram_binner_unit
// histogram with software-loaded, non-uniform bucket lower bounds
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall with command, sample, bucket_select
// and bound_value; every command returns one result transfer on
// o_out_valid / i_out_stall
// config channel: i_cfg_valid / o_cfg_ready writes active_buckets; write it
// only while no command is in flight
// add: clamp, binary search of the bound table (one table read per step,
// about log2(active_buckets) steps), then a read-modify-write of the count
// memory; the next command can be taken in the same cycle in which the
// result becomes valid
// bound write and bucket read: the selected count is read in S_CNT_WAIT, then returned from S_DONE
// clear: sweeps the count memory, then returns its result from S_DONE
// reset: the count memory is swept to zero with the input stalled; bounds
// are undefined until written
// a result held by a stalled receiver sits in the output register; the next
// command is taken meanwhile and its result waits until the register frees
// ----------------------------------------------------------------------------
module nonuniform_histogram_binner_unit #(
    parameter int MAX_BUCKETS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [nhb_pkg::CMD_W-1:0]       i_command,
    input  wire logic signed [nhb_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [nhb_pkg::BUCKET_W-1:0]    i_bucket_select,
    input  wire logic [nhb_pkg::VALUE_W-1:0]     i_bound_value,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [nhb_pkg::BUCKET_W-1:0]    o_bucket,
    output logic      [nhb_pkg::CNT_W-1:0]       o_bucket_tally,
    output logic      [nhb_pkg::SUM_W-1:0]       o_running_sum,
    output logic      [nhb_pkg::SUM_W-1:0]       o_running_square_sum,
    output logic      [nhb_pkg::TOTAL_W-1:0]     o_sample_total,
    // config channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [nhb_pkg::ACTIVE_W-1:0]    i_cfg_data
);
    import nhb_pkg::*;

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int LW = $clog2(MAX_BUCKETS + 1);
    localparam int XW = (BW > BUCKET_W) ? BW : BUCKET_W;
    localparam logic [BW-1:0] LAST_IDX = BW'(MAX_BUCKETS - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SEARCH,
        S_CNT_WAIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [ACTIVE_W-1:0] r_active;
    t_cmd                r_cmd;
    logic [BW-1:0]       r_idx;
    logic [BUCKET_W-1:0] r_bucket;
    logic [CNT_W-1:0]    r_tally;
    logic [BW-1:0]       r_sweep;
    logic                r_clr_cmd;
    logic                r_out_valid;
    logic [BUCKET_W-1:0] r_out_bucket;
    logic [CNT_W-1:0]    r_out_tally;
    t_stats              r_out_stats;

    t_cmd                cmd_in;
    logic                in_xfer;
    logic [VALUE_W-1:0]  value_clamped;
    logic [XW-1:0]       sel_ext;
    logic [BW-1:0]       sel_idx;
    logic                sel_ok;
    logic [LW-1:0]       limit;
    logic [31:0]         active_ext;
    logic                search_done;
    logic [BW-1:0]       search_bucket;
    logic [XW-1:0]       found_ext;
    logic                cnt_re;
    logic [BW-1:0]       cnt_raddr;
    logic                cnt_we;
    logic [BW-1:0]       cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CNT_W-1:0]    cnt_rdata;
    logic [CNT_W-1:0]    cnt_inc;
    logic                out_free;
    t_stats_ctl          stats_ctl;
    t_stats              stats;

    assign cmd_in     = t_cmd'(i_command);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // negatives count as zero, the top code as one below it
    always_comb begin
        if (i_sample[SAMPLE_W-1]) begin
            value_clamped = '0;
        end else if (i_sample[VALUE_W-1:0] == VALUE_MAX) begin
            value_clamped = TOP_SAMPLE;
        end else begin
            value_clamped = i_sample[VALUE_W-1:0];
        end
    end

    assign sel_ext = XW'(i_bucket_select);
    assign sel_idx = sel_ext[BW-1:0];
    assign sel_ok  = 32'(i_bucket_select) < MAX_BUCKETS;

    // active count clamped into 2..MAX_BUCKETS
    assign active_ext = 32'(r_active);
    always_comb begin
        if (active_ext > MAX_BUCKETS) begin
            limit = LW'(MAX_BUCKETS);
        end else if (active_ext < 2) begin
            limit = LW'(2);
        end else begin
            limit = LW'(active_ext);
        end
    end

    assign stats_ctl.add   = in_xfer && (cmd_in == CMD_ADD);
    assign stats_ctl.clear = in_xfer && (cmd_in == CMD_CLEAR);

    nhb_search #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (stats_ctl.add),
        .i_value   (value_clamped),
        .i_limit   (limit),
        .i_wr_en   (in_xfer && (cmd_in == CMD_WRITE_BOUND) && sel_ok),
        .i_wr_addr (sel_idx),
        .i_wr_data (i_bound_value),
        .o_done    (search_done),
        .o_bucket  (search_bucket)
    );

    nhb_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stats_ctl),
        .i_value (value_clamped),
        .o_stats (stats)
    );

    assign found_ext = XW'(search_bucket);

    // count memory: read at the selected or found bucket, write back the
    // incremented count, or zero during a sweep
    always_comb begin
        cnt_re    = 1'b0;
        cnt_raddr = sel_idx;
        if (r_state == S_SEARCH) begin
            cnt_re    = search_done;
            cnt_raddr = search_bucket;
        end else if (in_xfer && sel_ok &&
                     (cmd_in == CMD_WRITE_BOUND || cmd_in == CMD_READ)) begin
            cnt_re = 1'b1;
        end
    end

    assign cnt_inc = (cnt_rdata != CNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_idx;
        cnt_wdata = cnt_inc;
        if (r_state == S_SWEEP) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_sweep;
            cnt_wdata = '0;
        end else if (r_state == S_CNT_WAIT && r_cmd == CMD_ADD) begin
            cnt_we = 1'b1;
        end
    end

    nhb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BUCKETS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_clr_cmd   <= 1'b0;
            r_active    <= ACTIVE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            // output register loads a new result or empties on a transfer
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    if (r_sweep == LAST_IDX) begin
                        r_sweep <= '0;
                        r_state <= r_clr_cmd ? S_DONE : S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd    <= cmd_in;
                        r_idx    <= sel_idx;
                        r_bucket <= i_bucket_select;
                        r_tally  <= '0;
                        unique case (cmd_in) inside
                            CMD_ADD: begin
                                r_state <= S_SEARCH;
                            end
                            CMD_WRITE_BOUND, CMD_READ: begin
                                r_state <= sel_ok ? S_CNT_WAIT : S_DONE;
                            end
                            CMD_CLEAR: begin
                                r_sweep   <= '0;
                                r_clr_cmd <= 1'b1;
                                r_state   <= S_SWEEP;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (search_done) begin
                        r_idx    <= search_bucket;
                        r_bucket <= found_ext[BUCKET_W-1:0];
                        r_state  <= S_CNT_WAIT;
                    end
                end
                S_CNT_WAIT: begin
                    r_tally <= (r_cmd == CMD_ADD) ? cnt_inc : cnt_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_bucket <= r_bucket;
                        r_out_tally  <= r_tally;
                        r_out_stats  <= stats;
                        r_clr_cmd    <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_bucket             = r_out_bucket;
    assign o_bucket_tally       = r_out_tally;
    assign o_running_sum        = r_out_stats.sum;
    assign o_running_square_sum = r_out_stats.sq_sum;
    assign o_sample_total       = r_out_stats.total;

endmodule : nonuniform_histogram_binner_unit
`default_nettype wire

/* rtl/core/nhb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhb_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nhb_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : nhb_ram
`default_nettype wire

/* rtl/core/nhb_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhb_search
// bound table and binary search, one table read per step
// ----------------------------------------------------------------------------
module nhb_search #(
    parameter int MAX_BUCKETS = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [nhb_pkg::VALUE_W-1:0]          i_value,
    input  wire logic [$clog2(MAX_BUCKETS+1)-1:0]     i_limit,
    input  wire logic                                 i_wr_en,
    input  wire logic [$clog2(MAX_BUCKETS)-1:0]       i_wr_addr,
    input  wire logic [nhb_pkg::VALUE_W-1:0]          i_wr_data,
    output logic                                      o_done,
    output logic      [$clog2(MAX_BUCKETS)-1:0]       o_bucket
);
    import nhb_pkg::*;

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int LW = $clog2(MAX_BUCKETS + 1);

    logic               r_busy;
    logic [LW-1:0]      r_under;
    logic [LW-1:0]      r_over;
    logic [LW-1:0]      r_mid;
    logic [VALUE_W-1:0] r_value;

    logic [VALUE_W-1:0] bound_rdata;
    logic [LW-1:0]      under_c;
    logic [LW-1:0]      over_c;
    logic [LW:0]        mid_sum;
    logic [LW-1:0]      mid_c;
    logic [LW-1:0]      start_mid;
    logic               step_done;
    logic               rd_en;
    logic [BW-1:0]      rd_addr;

    // fold in the compare of the bound that just came back
    always_comb begin
        under_c = r_under;
        over_c  = r_over;
        if (r_busy) begin
            if (bound_rdata <= r_value) begin
                under_c = r_mid;
            end else begin
                over_c = r_mid;
            end
        end
        mid_sum = {1'b0, under_c} + {1'b0, over_c};
        mid_c   = mid_sum[LW:1];
    end

    assign start_mid = i_limit >> 1;
    assign step_done = r_busy && (mid_c == under_c);
    assign rd_en     = i_start || (r_busy && !step_done);
    assign rd_addr   = i_start ? start_mid[BW-1:0] : mid_c[BW-1:0];
    assign o_done    = step_done;
    assign o_bucket  = under_c[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_under <= '0;
            r_over  <= i_limit;
            r_mid   <= start_mid;
            r_value <= i_value;
        end else if (r_busy) begin
            if (step_done) begin
                r_busy <= 1'b0;
            end else begin
                r_under <= under_c;
                r_over  <= over_c;
                r_mid   <= mid_c;
            end
        end
    end

    nhb_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_BUCKETS)
    ) u_bound_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (bound_rdata)
    );

endmodule : nhb_search
`default_nettype wire

/* rtl/core/nhb_stats.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhb_stats
// saturating sum, sum of squares and sample total
// ----------------------------------------------------------------------------
module nhb_stats (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire nhb_pkg::t_stats_ctl         i_ctl,
    input  wire logic [nhb_pkg::VALUE_W-1:0] i_value,
    output nhb_pkg::t_stats                  o_stats
);
    import nhb_pkg::*;

    logic               r_add_d;
    logic [VALUE_W-1:0] r_value;
    logic [SQ_W-1:0]    r_square;
    t_stats             r_stats;

    logic [SUM_W:0]     sum_ext;
    logic [SUM_W:0]     sq_ext;

    assign sum_ext = {1'b0, r_stats.sum} + (SUM_W + 1)'(r_value);
    assign sq_ext  = {1'b0, r_stats.sq_sum} + (SUM_W + 1)'(r_square);

    always_ff @(posedge i_clk) begin
        r_value  <= i_value;
        r_square <= SQ_W'(i_value) * SQ_W'(i_value);
        if (!i_rst_n || i_ctl.clear) begin
            r_add_d <= 1'b0;
            r_stats <= '0;
        end else begin
            r_add_d <= i_ctl.add;
            if (r_add_d) begin
                r_stats.sum    <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                r_stats.sq_sum <= sq_ext[SUM_W] ? SUM_MAX : sq_ext[SUM_W-1:0];
                if (r_stats.total != TOTAL_MAX) begin
                    r_stats.total <= r_stats.total + 1'b1;
                end
            end
        end
    end

    assign o_stats = r_stats;

endmodule : nhb_stats
`default_nettype wire
